// ----- hw/rtl/cbt_pkg.sv -----
// Shared constants and types for the control binding table.
`default_nettype none
package cbt_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int SLOT_W = 4;
    localparam int COUNT_OUT_W = 5;
    localparam int NUM_W = 39;
    localparam int DIGIT_W = 7;

    localparam logic [2:0] OP_FEED = 3'd0;
    localparam logic [2:0] OP_BIND = 3'd1;
    localparam logic [2:0] OP_UNBIND = 3'd2;
    localparam logic [2:0] OP_LEARN_BEGIN = 3'd3;
    localparam logic [2:0] OP_LEARN_CANCEL = 3'd4;

    localparam logic [1:0] MODE_MOMENTARY = 2'd0;
    localparam logic [1:0] MODE_TOGGLE = 2'd1;

    localparam logic [1:0] SRC_NONE = 2'd0;

    localparam logic signed [15:0] RAW_DOWN = 16'sd64;
    localparam logic signed [15:0] RAW_TOP = 16'sd127;
    localparam logic [NUM_W-1:0] DIVISOR = NUM_W'(127);
    localparam logic [NUM_W-1:0] HALF = NUM_W'(63);

    typedef struct packed {
        logic [15:0]        source;
        logic [31:0]        param;
        logic signed [31:0] low;
        logic signed [31:0] high;
        logic [1:0]         mode;
        logic               toggle;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

// ----- hw/rtl/cbt_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module cbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                        clk,
    input  wire logic                                        wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                            wr_data,
    input  wire logic                                        rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                                 rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/control_binding_table_with_learn.sv -----
// Control binding table with learn: maps control sources to parameters.
//
// The block takes one request at a time. Learn begin, learn cancel, unknown
// operations and requests without a source go straight to the finish state,
// and the next request is accepted once the finish state has loaded the output
// register. Feed, bind and unbind walk the binding RAM: the scan state issues
// the first read and then compares each entry in turn, stopping at the first
// match or after the last entry; the decide state updates the entry, and the
// finish state loads the output register. A continuous-mode feed adds a
// multiply state, division by 127 done by folding 7-bit digits, and a sum
// state before the finish state. The finish state waits while the output
// register still holds a result that has not been taken.
`default_nettype none
module control_binding_table_with_learn
    import cbt_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [2:0]         operation,
    input  wire logic [1:0]         src_type,
    input  wire logic [13:0]        src_id,
    input  wire logic signed [15:0] raw,
    input  wire logic [31:0]        target_param,
    input  wire logic signed [31:0] out_min,
    input  wire logic signed [31:0] out_max,
    input  wire logic [1:0]         mode,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    emitted,
    output logic [31:0]             param_out,
    output logic signed [31:0]      value_out,
    output logic [SLOT_W-1:0]       slot_index,
    output logic                    status,
    output logic                    learn_pending,
    output logic [COUNT_OUT_W-1:0]  bound_count
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_DECIDE = 3'd2;
    localparam logic [2:0] ST_MUL = 3'd3;
    localparam logic [2:0] ST_DIV = 3'd4;
    localparam logic [2:0] ST_SUM = 3'd5;
    localparam logic [2:0] ST_FINISH = 3'd6;

    logic [2:0]               state_reg;
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [CNT_W-1:0]         count_reg;
    logic                     learn_armed_reg;
    logic [31:0]              learn_target_reg;
    logic                     out_valid_reg;
    logic                     cmp_pending_reg;

    logic [2:0]               op_reg;
    logic [15:0]              key_reg;
    logic signed [15:0]       raw_reg;
    logic [31:0]              par_reg;
    logic signed [31:0]       lo_reg;
    logic signed [31:0]       hi_reg;
    logic [1:0]               md_reg;
    logic signed [31:0]       learn_low_reg;
    logic signed [31:0]       learn_high_reg;
    logic [1:0]               learn_kind_reg;
    logic [IDX_W-1:0]         scan_addr_reg;
    logic [IDX_W-1:0]         cmp_idx_reg;
    logic                     hit_reg;
    logic [IDX_W-1:0]         hit_idx_reg;
    entry_t                   hit_data_reg;
    logic [31:0]              mag_reg;
    logic [6:0]               r_reg;
    logic                     neg_reg;
    logic signed [31:0]       base_reg;
    logic [NUM_W-1:0]         num_reg;
    logic [NUM_W-1:0]         quo_reg;
    logic                     res_emit_reg;
    logic [31:0]              res_param_reg;
    logic signed [31:0]       res_value_reg;
    logic [SLOT_W-1:0]        res_slot_reg;
    logic                     res_status_reg;
    logic                     out_emit_reg;
    logic [31:0]              out_param_reg;
    logic signed [31:0]       out_value_reg;
    logic [SLOT_W-1:0]        out_slot_reg;
    logic                     out_status_reg;
    logic                     out_learn_reg;
    logic [COUNT_OUT_W-1:0]   out_count_reg;

    logic                     accept;
    logic                     ram_we;
    logic [IDX_W-1:0]         ram_waddr;
    entry_t                   ram_wdata;
    entry_t                   rd_entry;
    logic [ENTRY_W-1:0]       rd_bits;
    logic                     match;
    logic                     scan_end;
    logic                     free_any;
    logic [IDX_W-1:0]         free_idx;
    logic                     learn_feed;
    logic                     found;
    logic                     claim_free;
    logic [IDX_W-1:0]         sel_idx;
    entry_t                   ent;
    entry_t                   ent_next;
    logic                     down;
    logic signed [32:0]       span;
    logic [32:0]              span_mag;
    logic [6:0]               r_clamp;
    logic                     fold;
    logic signed [33:0]       q_signed;
    logic signed [33:0]       sum;
    logic                     finish_go;

    assign accept = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign rd_entry = entry_t'(rd_bits);

    cbt_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(TABLE_ENTRIES)
    ) u_ram (
        .clk    (clk),
        .wr_en  (ram_we),
        .wr_addr(ram_waddr),
        .wr_data(ram_wdata),
        .rd_en  (state_reg == ST_SCAN),
        .rd_addr(scan_addr_reg),
        .rd_data(rd_bits)
    );

    assign match = cmp_pending_reg && valid_reg[cmp_idx_reg] && (rd_entry.source == key_reg);
    assign scan_end = cmp_pending_reg && (cmp_idx_reg == IDX_W'(TABLE_ENTRIES - 1));

    always_comb
    begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_any = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    assign learn_feed = (op_reg == OP_FEED) && learn_armed_reg;
    assign sel_idx = hit_reg ? hit_idx_reg : free_idx;
    assign claim_free = !hit_reg && free_any;
    assign down = (raw_reg >= RAW_DOWN);

    always_comb
    begin
        if (learn_feed)
        begin
            ent = '{source: key_reg, param: learn_target_reg, low: learn_low_reg,
                    high: learn_high_reg, mode: learn_kind_reg, toggle: 1'b0};
            found = hit_reg || free_any;
        end
        else if (op_reg == OP_BIND)
        begin
            ent = '{source: key_reg, param: par_reg, low: lo_reg, high: hi_reg,
                    mode: md_reg, toggle: 1'b0};
            found = hit_reg || free_any;
        end
        else
        begin
            ent = hit_data_reg;
            found = hit_reg;
        end
        ent_next = ent;
        if ((op_reg == OP_FEED) && (ent.mode == MODE_TOGGLE) && down)
        begin
            ent_next.toggle = !ent.toggle;
        end
    end

    always_comb
    begin
        ram_we = 1'b0;
        if ((state_reg == ST_DECIDE) && found)
        begin
            if ((op_reg == OP_BIND) || learn_feed)
            begin
                ram_we = 1'b1;
            end
            else if ((op_reg == OP_FEED) && (ent.mode == MODE_TOGGLE) && down)
            begin
                ram_we = 1'b1;
            end
        end
    end
    assign ram_waddr = sel_idx;
    assign ram_wdata = ent_next;

    assign span = 33'(ent.high) - 33'(ent.low);
    assign span_mag = span[32] ? 33'(-span) : 33'(span);
    always_comb
    begin
        if (raw_reg < 16'sd0)
        begin
            r_clamp = 7'd0;
        end
        else if (raw_reg > RAW_TOP)
        begin
            r_clamp = 7'd127;
        end
        else
        begin
            r_clamp = raw_reg[6:0];
        end
    end

    assign fold = (num_reg[NUM_W-1:DIGIT_W] != '0);
    assign q_signed = neg_reg ? -34'(quo_reg) : 34'(quo_reg);
    assign sum = 34'(base_reg) + q_signed;
    assign finish_go = (state_reg == ST_FINISH) && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= '0;
            count_reg <= '0;
            learn_armed_reg <= 1'b0;
            learn_target_reg <= '0;
            out_valid_reg <= 1'b0;
            cmp_pending_reg <= 1'b0;
        end
        else
        begin
            if (finish_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    cmp_pending_reg <= 1'b0;
                    if (accept)
                    begin
                        if ((operation inside {OP_FEED, OP_BIND, OP_UNBIND}) &&
                            (src_type != SRC_NONE))
                        begin
                            state_reg <= ST_SCAN;
                        end
                        else
                        begin
                            state_reg <= ST_FINISH;
                        end
                        case (operation)
                            OP_LEARN_BEGIN:
                            begin
                                learn_armed_reg <= 1'b1;
                                learn_target_reg <= target_param;
                            end
                            OP_LEARN_CANCEL:
                            begin
                                learn_armed_reg <= 1'b0;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_SCAN:
                begin
                    cmp_pending_reg <= 1'b1;
                    if (match || scan_end)
                    begin
                        state_reg <= ST_DECIDE;
                    end
                end
                ST_DECIDE:
                begin
                    if ((op_reg == OP_FEED) && found && (ent.mode[1] == 1'b1))
                    begin
                        state_reg <= ST_MUL;
                    end
                    else
                    begin
                        state_reg <= ST_FINISH;
                    end
                    if (learn_feed)
                    begin
                        learn_armed_reg <= 1'b0;
                    end
                    if (((op_reg == OP_BIND) || learn_feed) && claim_free)
                    begin
                        valid_reg[free_idx] <= 1'b1;
                        count_reg <= count_reg + CNT_W'(1);
                    end
                    if ((op_reg == OP_UNBIND) && hit_reg)
                    begin
                        valid_reg[hit_idx_reg] <= 1'b0;
                        count_reg <= count_reg - CNT_W'(1);
                    end
                end
                ST_MUL:
                begin
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (num_reg < DIVISOR)
                    begin
                        state_reg <= ST_SUM;
                    end
                end
                ST_SUM:
                begin
                    state_reg <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    if (finish_go)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                scan_addr_reg <= '0;
                hit_reg <= 1'b0;
                if (accept)
                begin
                    op_reg <= operation;
                    key_reg <= {src_type, src_id};
                    raw_reg <= raw;
                    par_reg <= target_param;
                    lo_reg <= out_min;
                    hi_reg <= out_max;
                    md_reg <= mode;
                    res_emit_reg <= 1'b0;
                    res_param_reg <= '0;
                    res_value_reg <= '0;
                    res_slot_reg <= '0;
                    res_status_reg <= !((operation == OP_LEARN_BEGIN) ||
                                        (operation == OP_LEARN_CANCEL));
                    if (operation == OP_LEARN_BEGIN)
                    begin
                        learn_low_reg <= out_min;
                        learn_high_reg <= out_max;
                        learn_kind_reg <= mode;
                    end
                end
            end
            ST_SCAN:
            begin
                scan_addr_reg <= scan_addr_reg + IDX_W'(1);
                cmp_idx_reg <= scan_addr_reg;
                if (match)
                begin
                    hit_reg <= 1'b1;
                    hit_idx_reg <= cmp_idx_reg;
                    hit_data_reg <= rd_entry;
                end
            end
            ST_DECIDE:
            begin
                mag_reg <= span_mag[31:0];
                neg_reg <= span[32];
                r_reg <= r_clamp;
                base_reg <= ent.low;
                if (found)
                begin
                    if ((op_reg == OP_BIND) || learn_feed)
                    begin
                        res_slot_reg <= SLOT_W'(sel_idx);
                    end
                    if (op_reg != OP_FEED)
                    begin
                        res_status_reg <= 1'b0;
                    end
                    else
                    begin
                        res_status_reg <= 1'b0;
                        if (ent.mode == MODE_MOMENTARY)
                        begin
                            res_emit_reg <= 1'b1;
                            res_param_reg <= ent.param;
                            res_value_reg <= down ? ent.high : ent.low;
                        end
                        else if (ent.mode == MODE_TOGGLE)
                        begin
                            if (down)
                            begin
                                res_emit_reg <= 1'b1;
                                res_param_reg <= ent.param;
                                res_value_reg <= ent_next.toggle ? ent.high : ent.low;
                            end
                        end
                        else
                        begin
                            res_emit_reg <= 1'b1;
                            res_param_reg <= ent.param;
                        end
                    end
                end
            end
            ST_MUL:
            begin
                num_reg <= NUM_W'(mag_reg) * NUM_W'(r_reg) + HALF;
                quo_reg <= '0;
            end
            ST_DIV:
            begin
                // Since 128 is one more than 127, the value above the lowest 7-bit digit
                // adds itself to the quotient and to the remainder.
                if (fold)
                begin
                    num_reg <= NUM_W'(num_reg[NUM_W-1:DIGIT_W]) +
                               NUM_W'(num_reg[DIGIT_W-1:0]);
                    quo_reg <= quo_reg + NUM_W'(num_reg[NUM_W-1:DIGIT_W]);
                end
                else if (num_reg >= DIVISOR)
                begin
                    num_reg <= num_reg - DIVISOR;
                    quo_reg <= quo_reg + NUM_W'(1);
                end
            end
            ST_SUM:
            begin
                res_value_reg <= sum[31:0];
            end
            ST_FINISH:
            begin
                if (finish_go)
                begin
                    out_emit_reg <= res_emit_reg;
                    out_param_reg <= res_param_reg;
                    out_value_reg <= res_value_reg;
                    out_slot_reg <= res_slot_reg;
                    out_status_reg <= res_status_reg;
                    out_learn_reg <= learn_armed_reg;
                    out_count_reg <= COUNT_OUT_W'(count_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign emitted = out_emit_reg;
    assign param_out = out_param_reg;
    assign value_out = out_value_reg;
    assign slot_index = out_slot_reg;
    assign status = out_status_reg;
    assign learn_pending = out_learn_reg;
    assign bound_count = out_count_reg;

endmodule
`default_nettype wire
